[hw/rtl/dwc_pkg.sv]
// ----------------------------------------------------------------------------
// dwc_pkg: shared types and constants of the wall column caster
// Register indexes, controller states, divider selects and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package dwc_pkg;

  localparam int MapSizeDef     = 32;
  localparam int ScreenWidthDef = 320;
  localparam int TexSizeDef     = 8;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;
  localparam int DivW     = 32;
  localparam int CamW     = 27;
  localparam int RayW     = 30;
  localparam int DeltaW   = 41;
  localparam int SideW    = 48;

  localparam logic [15:0] DistMin = 16'd13;

  typedef enum logic [CfgAddrW-1:0] {
    REG_POS_X, REG_POS_Y, REG_DIR_X, REG_DIR_Y,
    REG_PLANE_X, REG_PLANE_Y, REG_SCREEN_HEIGHT, REG_HORIZON_ROW
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIV_DX, DIV_DY, DIV_LH
  } div_sel_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CAM, S_RAY, S_DX, S_DX_W, S_DY, S_DY_W, S_INIT,
    S_STEP, S_LOOK, S_CHECK, S_DIST, S_LH, S_LH_W, S_WALL, S_FINISH
  } state_e;

  typedef struct packed {
    logic     accept;
    logic     cam_load;
    logic     div_start;
    logic     div_load;
    div_sel_e div_sel;
    logic     ray_load;
    logic     init;
    logic     step;
    logic     check;
    logic     dist_load;
    logic     wall_load;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic stop;
  } status_t;

endpackage

[hw/rtl/dwc_divider.sv]
// ----------------------------------------------------------------------------
// dwc_divider: shared restoring divider
// Unsigned 32-bit by 32-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dwc_divider import dwc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quotient_o
);

  logic [DivW:0]   rem_q, rem_d, trial;
  logic [DivW-1:0] quo_q, quo_d, den_q;
  logic [5:0]      cnt_q, cnt_d;
  logic            done_q, done_d;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q[DivW-1:0], quo_q[DivW-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = 6'(DivW);
    end else if (cnt_q != 6'd0) begin
      if (!trial[DivW]) begin
        rem_d = trial;
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivW-1:0], quo_q[DivW-1]};
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= divisor_i;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[hw/rtl/dwc_ctrl.sv]
// ----------------------------------------------------------------------------
// dwc_ctrl: sequencer of the wall column caster
// Walks one cast through divisions, DDA steps and wall math, and owns
// the handshakes of both channels.
// ----------------------------------------------------------------------------
module dwc_ctrl import dwc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    func_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_busy;

  assign out_busy   = out_valid_q && !out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i && func_i) state_d = S_CAM;
      S_CAM:    state_d = S_RAY;
      S_RAY:    state_d = S_DX;
      S_DX:     state_d = S_DX_W;
      S_DX_W:   if (status_i.div_done) state_d = S_DY;
      S_DY:     state_d = S_DY_W;
      S_DY_W:   if (status_i.div_done) state_d = S_INIT;
      S_INIT:   state_d = S_STEP;
      S_STEP:   state_d = S_LOOK;
      S_LOOK:   state_d = S_CHECK;
      S_CHECK:  state_d = status_i.stop ? S_DIST : S_STEP;
      S_DIST:   state_d = S_LH;
      S_LH:     state_d = S_LH_W;
      S_LH_W:   if (status_i.div_done) state_d = S_WALL;
      S_WALL:   state_d = S_FINISH;
      S_FINISH: if (!out_busy) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = DIV_DX;
    case (state_q)
      S_IDLE:   cmd_o.accept = in_valid_i;
      S_CAM:    cmd_o.cam_load = 1'b1;
      S_RAY:    cmd_o.ray_load = 1'b1;
      S_DX: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_DX;
      end
      S_DX_W: begin
        cmd_o.div_load = status_i.div_done;
        cmd_o.div_sel  = DIV_DX;
      end
      S_DY: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_DY;
      end
      S_DY_W: begin
        cmd_o.div_load = status_i.div_done;
        cmd_o.div_sel  = DIV_DY;
      end
      S_INIT:   cmd_o.init = 1'b1;
      S_STEP:   cmd_o.step = 1'b1;
      S_CHECK:  cmd_o.check = 1'b1;
      S_DIST:   cmd_o.dist_load = 1'b1;
      S_LH: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_LH;
      end
      S_LH_W: begin
        cmd_o.div_load = status_i.div_done;
        cmd_o.div_sel  = DIV_LH;
      end
      S_WALL:   cmd_o.wall_load = 1'b1;
      S_FINISH: cmd_o.out_load = !out_busy;
      default:  cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten");

  // The divider is not started twice in a row, and its done does not follow a start at once.
  a_start_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !cmd_o.div_start && !status_i.div_done)
    else $error("divider restarted");

  // No input transaction is taken in the step and check states of a cast.
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP || state_q == S_CHECK) |-> !cmd_o.accept)
    else $error("input accepted during cast");

endmodule

[hw/rtl/dwc_datapath.sv]
// ----------------------------------------------------------------------------
// dwc_datapath: arithmetic, configuration and tile map of the caster
// Holds the registers, the map memory and the shared divider.
// ----------------------------------------------------------------------------
module dwc_datapath import dwc_pkg::*; #(
  parameter int MAP_SIZE     = MapSizeDef,
  parameter int SCREEN_WIDTH = ScreenWidthDef,
  parameter int TEX_SIZE     = TexSizeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                func_i,
  input  logic [4:0]          cell_x_i,
  input  logic [4:0]          cell_y_i,
  input  logic [3:0]          cell_tile_i,
  input  logic                cell_solid_i,
  input  logic [9:0]          column_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  output logic [9:0]          column_out_o,
  output logic [15:0]         wall_distance_o,
  output logic                hit_side_o,
  output logic [3:0]          hit_tile_o,
  output logic [2:0]          tex_column_o,
  output logic [9:0]          span_top_o,
  output logic [9:0]          span_bottom_o
);

  localparam int IW    = $clog2(MAP_SIZE);
  localparam int AW    = $clog2(MAP_SIZE * MAP_SIZE);
  localparam int Depth = MAP_SIZE * MAP_SIZE;
  localparam int MXW   = ((IW > 5) ? IW : 5) + 2;
  localparam int Limit = 2 * MAP_SIZE + 4;
  localparam int NW    = $clog2(Limit + 1);

  // Reciprocal of the screen width, exact for every 10-bit column.
  localparam logic [35:0] CamRecip =
    36'(((64'd1 << 35) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

  // Configuration registers.
  logic [12:0]        pos_x_q, pos_y_q;
  logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [9:0]         sh_q, hz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= 13'd4224;
      pos_y_q   <= 13'd4224;
      dir_x_q   <= 16'sd16384;
      dir_y_q   <= 16'sd0;
      plane_x_q <= 16'sd0;
      plane_y_q <= 16'sd10813;
      sh_q      <= 10'd240;
      hz_q      <= 10'd120;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_POS_X:         pos_x_q   <= cfg_data_i[12:0];
        REG_POS_Y:         pos_y_q   <= cfg_data_i[12:0];
        REG_DIR_X:         dir_x_q   <= cfg_data_i;
        REG_DIR_Y:         dir_y_q   <= cfg_data_i;
        REG_PLANE_X:       plane_x_q <= cfg_data_i;
        REG_PLANE_Y:       plane_y_q <= cfg_data_i;
        REG_SCREEN_HEIGHT: sh_q      <= cfg_data_i[9:0];
        REG_HORIZON_ROW:   hz_q      <= cfg_data_i[9:0];
        default:           ;
      endcase
    end
  end

  // Tile map: bit 4 solid, bits 3..0 tile.
  logic [4:0]    mem [Depth];
  logic [4:0]    rd_q;
  logic [AW-1:0] waddr, raddr;
  logic          wr_in_map;
  logic signed [MXW-1:0] mx_q, my_q;

  assign wr_in_map = ({27'd0, cell_x_i} < 32'(MAP_SIZE)) &&
                     ({27'd0, cell_y_i} < 32'(MAP_SIZE));
  assign waddr = AW'(AW'(cell_y_i) * AW'(MAP_SIZE) + AW'(cell_x_i));
  assign raddr = AW'(AW'(my_q[IW-1:0]) * AW'(MAP_SIZE) + AW'(mx_q[IW-1:0]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !func_i && wr_in_map) mem[waddr] <= {cell_solid_i, cell_tile_i};
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[raddr];
  end

  // Shared divider.
  logic            div_done;
  logic [DivW-1:0] dividend, divisor, quo;
  logic signed [RayW-1:0] rx_q, ry_q;
  logic [RayW-1:0] abs_rx, abs_ry;
  logic [15:0]     d_q;
  logic [9:0]      column_q;

  assign abs_rx = rx_q[RayW-1] ? RayW'(-rx_q) : RayW'(rx_q);
  assign abs_ry = ry_q[RayW-1] ? RayW'(-ry_q) : RayW'(ry_q);

  always_comb begin
    case (cmd_i.div_sel)
      DIV_DX: begin
        dividend = DivW'(1) << 30;
        divisor  = DivW'(abs_rx);
      end
      DIV_DY: begin
        dividend = DivW'(1) << 30;
        divisor  = DivW'(abs_ry);
      end
      DIV_LH: begin
        dividend = DivW'({sh_q, 8'd0});
        divisor  = DivW'(d_q);
      end
      default: begin
        dividend = '0;
        divisor  = '0;
      end
    endcase
  end

  dwc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Cast registers.
  logic signed [CamW-1:0] cam_q;
  logic [DeltaW-1:0]      dx_q, dy_q;
  logic                   dx_inf_q, dy_inf_q;
  logic [SideW-1:0]       sdx_q, sdy_q;
  logic                   side_q;
  logic [NW-1:0]          n_q;
  logic [15:0]            lh_q;
  logic [15:0]            frac_q;
  logic [9:0]             y0_q, y1_q;
  logic [3:0]             tile_q;
  logic [4:0]             hit_cell;
  logic                   outside;

  logic [45:0]             cam_prod;
  logic signed [15+CamW:0] px_prod, py_prod;
  logic [8:0]              fx, fy;
  logic [39:0]             sdx_mul, sdy_mul;
  logic [SideW-1:0]        dist_raw;
  logic signed [16+RayW:0] w_prod;
  logic signed [17:0]      half, y0, y1, hm1;
  logic [22:0]             tex_prod;
  logic [6:0]              tex_raw, tex_cl;

  assign cam_prod = 46'(column_q) * 46'(CamRecip);
  assign px_prod = plane_x_q * cam_q;
  assign py_prod = plane_y_q * cam_q;
  assign fx = rx_q[RayW-1] ? {1'b0, pos_x_q[7:0]} : 9'd256 - {1'b0, pos_x_q[7:0]};
  assign fy = ry_q[RayW-1] ? {1'b0, pos_y_q[7:0]} : 9'd256 - {1'b0, pos_y_q[7:0]};
  assign sdx_mul = 40'(fx) * 40'(dx_q[30:0]);
  assign sdy_mul = 40'(fy) * 40'(dy_q[30:0]);

  assign outside = (mx_q < 0) || (my_q < 0) ||
                   (mx_q >= $signed(MXW'(MAP_SIZE))) || (my_q >= $signed(MXW'(MAP_SIZE)));
  assign hit_cell = outside ? 5'h10 : rd_q;

  assign dist_raw = side_q ? (sdy_q - SideW'(dy_q)) : (sdx_q - SideW'(dx_q));
  assign w_prod   = $signed({1'b0, d_q}) * (side_q ? rx_q : ry_q);
  assign half     = $signed({3'd0, lh_q[15:1]});
  assign y0       = $signed({8'd0, hz_q}) - half;
  assign y1       = $signed({8'd0, hz_q}) + half;
  assign hm1      = $signed({8'd0, sh_q}) - 18'sd1;
  assign tex_prod = 23'(frac_q) * 23'(TEX_SIZE);
  assign tex_raw  = tex_prod[22:16];
  assign tex_cl   = (tex_raw > 7'(TEX_SIZE - 1)) ? 7'(TEX_SIZE - 1) : tex_raw;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) column_q <= column_i;
    if (cmd_i.cam_load) cam_q <= CamW'(cam_prod >> 20) - CamW'(16384);
    if (cmd_i.div_load) begin
      case (cmd_i.div_sel)
        DIV_DX: begin
          dx_inf_q <= (abs_rx == '0);
          dx_q     <= (abs_rx == '0) ? (DeltaW'(1) << 40) : DeltaW'(quo[30:0]);
        end
        DIV_DY: begin
          dy_inf_q <= (abs_ry == '0);
          dy_q     <= (abs_ry == '0) ? (DeltaW'(1) << 40) : DeltaW'(quo[30:0]);
        end
        DIV_LH:  lh_q <= quo[15:0];
        default: ;
      endcase
    end
    if (cmd_i.ray_load) begin
      rx_q <= RayW'(dir_x_q) + RayW'(px_prod >>> 14);
      ry_q <= RayW'(dir_y_q) + RayW'(py_prod >>> 14);
    end
    if (cmd_i.init) begin
      sdx_q  <= dx_inf_q ? (SideW'(fx) << 32) : SideW'(sdx_mul >> 8);
      sdy_q  <= dy_inf_q ? (SideW'(fy) << 32) : SideW'(sdy_mul >> 8);
      mx_q   <= MXW'(pos_x_q[12:8]);
      my_q   <= MXW'(pos_y_q[12:8]);
      side_q <= 1'b0;
    end
    if (cmd_i.step) begin
      if (sdx_q < sdy_q) begin
        sdx_q  <= sdx_q + SideW'(dx_q);
        mx_q   <= rx_q[RayW-1] ? mx_q - MXW'(1) : mx_q + MXW'(1);
        side_q <= 1'b0;
      end else begin
        sdy_q  <= sdy_q + SideW'(dy_q);
        my_q   <= ry_q[RayW-1] ? my_q - MXW'(1) : my_q + MXW'(1);
        side_q <= 1'b1;
      end
    end
    if (cmd_i.dist_load) begin
      if ((dist_raw >> 8) < SideW'(DistMin)) d_q <= DistMin;
      else if ((dist_raw >> 8) > SideW'(16'hFFFF)) d_q <= 16'hFFFF;
      else d_q <= dist_raw[23:8];
    end
    if (cmd_i.wall_load) begin
      frac_q <= {(side_q ? pos_x_q[7:0] : pos_y_q[7:0]), 8'd0} + 16'(w_prod >>> 6);
      y0_q   <= (y0 < 0) ? 10'd0 : y0[9:0];
      y1_q   <= (y1 > hm1) ? ((hm1 < 0) ? 10'd0 : hm1[9:0]) : y1[9:0];
    end
    if (cmd_i.check) tile_q <= hit_cell[3:0];
    if (cmd_i.out_load) begin
      column_out_o    <= column_q;
      wall_distance_o <= d_q;
      hit_side_o      <= side_q;
      hit_tile_o      <= tile_q;
      tex_column_o    <= tex_cl[2:0];
      span_top_o      <= y0_q;
      span_bottom_o   <= y1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (cmd_i.init) begin
      n_q <= '0;
    end else if (cmd_i.step) begin
      n_q <= n_q + NW'(1);
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.stop     = hit_cell[4] || (n_q == NW'(Limit));

endmodule

[hw/rtl/dda_wall_column_caster_core.sv]
// ----------------------------------------------------------------------------
// dda_wall_column_caster_core: DDA ray caster for one wall column
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage. The input channel carries two kinds of transaction. With func_i low
// it writes one tile map cell in the cycle it is accepted and gives no result.
// With func_i high it casts the ray of screen column column_i and gives one
// result transaction on the output channel: distance, side, tile, texture
// column and wall span. Software loads every map cell before it casts.
// Configuration registers are to be written through cfg_we_i/cfg_addr_i/
// cfg_data_i only while the block is idle, which the block itself does not
// enforce; each write takes effect at once. A cast takes 1 to 2*MAP_SIZE+4
// DDA cell steps and runs three divisions on the shared one-bit-per-cycle
// divider; every cell step passes through the step, look and check states,
// the look state covering the map memory read, and setup and wall math come
// around them. The next transaction is taken in the cycle after the result
// is loaded; after a map write the block stays idle. Reset
// brings the registers to their defaults and empties the result register;
// the map contents are undefined until written. A result waits in its output
// register while the receiver stalls, and a new item is taken meanwhile; the
// next cast holds at its end until it drains.
// ----------------------------------------------------------------------------
module dda_wall_column_caster_core import dwc_pkg::*; #(
  parameter int MAP_SIZE     = MapSizeDef,
  parameter int SCREEN_WIDTH = ScreenWidthDef,
  parameter int TEX_SIZE     = TexSizeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [4:0]          cell_x_i,
  input  logic [4:0]          cell_y_i,
  input  logic [3:0]          cell_tile_i,
  input  logic                cell_solid_i,
  input  logic [9:0]          column_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [9:0]          column_out_o,
  output logic [15:0]         wall_distance_o,
  output logic                hit_side_o,
  output logic [3:0]          hit_tile_o,
  output logic [2:0]          tex_column_o,
  output logic [9:0]          span_top_o,
  output logic [9:0]          span_bottom_o
);

  cmd_t    cmd;
  status_t status;

  // The sequencer steps through the cast and runs both handshakes.
  dwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds configuration, the map memory and all arithmetic.
  dwc_datapath #(
    .MAP_SIZE     (MAP_SIZE),
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .TEX_SIZE     (TEX_SIZE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (func_i),
    .cell_x_i        (cell_x_i),
    .cell_y_i        (cell_y_i),
    .cell_tile_i     (cell_tile_i),
    .cell_solid_i    (cell_solid_i),
    .column_i        (column_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .column_out_o    (column_out_o),
    .wall_distance_o (wall_distance_o),
    .hit_side_o      (hit_side_o),
    .hit_tile_o      (hit_tile_o),
    .tex_column_o    (tex_column_o),
    .span_top_o      (span_top_o),
    .span_bottom_o   (span_bottom_o)
  );

endmodule

[sim/dwc_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dwc_checker: result predictor and scoreboard for the wall column caster
// Watches the configuration port and both channels, keeps its own copy of the
// registers and the tile map, predicts one hit per cast and compares it.
// ----------------------------------------------------------------------------
module dwc_checker import dwc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                func_i,
  input  logic [4:0]          cell_x_i,
  input  logic [4:0]          cell_y_i,
  input  logic [3:0]          cell_tile_i,
  input  logic                cell_solid_i,
  input  logic [9:0]          column_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [9:0]          column_out_i,
  input  logic [15:0]         wall_distance_i,
  input  logic                hit_side_i,
  input  logic [3:0]          hit_tile_i,
  input  logic [2:0]          tex_column_i,
  input  logic [9:0]          span_top_i,
  input  logic [9:0]          span_bottom_i,
  output int                  err_count_o,
  output int                  pending_o
);

  localparam int MapSize = MapSizeDef;
  localparam int ScreenW = ScreenWidthDef;
  localparam int TexSize = TexSizeDef;

  typedef struct packed {
    logic [9:0]  column;
    logic [15:0] distance;
    logic        side;
    logic [3:0]  tile;
    logic [2:0]  tex;
    logic [9:0]  top;
    logic [9:0]  bottom;
  } hit_t;

  logic [12:0]        view_x, view_y;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
  logic [9:0]         scr_h, horizon;
  logic [4:0]         tile_map [MapSize*MapSize];
  hit_t               hits_due [$];

  function automatic logic [4:0] map_cell(input longint cx, input longint cy);
    if (cx < 0 || cy < 0 || cx >= MapSize || cy >= MapSize) return 5'h10;
    return tile_map[cy*MapSize + cx];
  endfunction

  function automatic longint inv_delta(input longint r);
    longint a;
    a = (r < 0) ? -r : r;
    return (a == 0) ? (longint'(1) << 40) : (longint'(1) << 30) / a;
  endfunction

  function automatic hit_t cast_ray(input logic [9:0] col);
    longint cam, rx, ry, dx, dy, mx, my, sx, sy, sdx, sdy, d, lh, y0, y1;
    longint wall, frac, tx, px, py;
    logic       side;
    logic [4:0] hit_cell;
    hit_t       h;
    px = longint'(view_x);
    py = longint'(view_y);
    cam = ((longint'(col) * 2) << 14) / ScreenW - 16384;
    rx = longint'(dir_x) + ((longint'(plane_x) * cam) >>> 14);
    ry = longint'(dir_y) + ((longint'(plane_y) * cam) >>> 14);
    dx = inv_delta(rx);
    dy = inv_delta(ry);
    mx = px >> 8;
    my = py >> 8;
    if (rx < 0) begin
      sx = -1; sdx = ((px - mx*256) * dx) >> 8;
    end else begin
      sx = 1; sdx = ((mx*256 + 256 - px) * dx) >> 8;
    end
    if (ry < 0) begin
      sy = -1; sdy = ((py - my*256) * dy) >> 8;
    end else begin
      sy = 1; sdy = ((my*256 + 256 - py) * dy) >> 8;
    end
    side = 1'b0;
    hit_cell = '0;
    // Walk the grid until a solid cell; the map border always stops the walk.
    for (int n = 0; n < 2*MapSize + 4; n++) begin
      if (sdx < sdy) begin
        sdx += dx; mx += sx; side = 1'b0;
      end else begin
        sdy += dy; my += sy; side = 1'b1;
      end
      hit_cell = map_cell(mx, my);
      if (hit_cell[4]) break;
    end
    d = ((side == 1'b0) ? sdx - dx : sdy - dy) >> 8;
    if (d < DistMin) d = DistMin;
    if (d > 65535) d = 65535;
    lh = (longint'(scr_h) << 8) / d;
    y0 = longint'(horizon) - lh/2;
    y1 = longint'(horizon) + lh/2;
    if (y0 < 0) y0 = 0;
    if (y1 > longint'(scr_h) - 1) y1 = longint'(scr_h) - 1;
    if (y1 < 0) y1 = 0;
    wall = (side == 1'b0) ? (py << 8) + ((d * ry) >>> 6)
                          : (px << 8) + ((d * rx) >>> 6);
    frac = wall & 64'hFFFF;
    tx = (frac * TexSize) >> 16;
    if (tx > TexSize - 1) tx = TexSize - 1;
    h.column   = col;
    h.distance = d[15:0];
    h.side     = side;
    h.tile     = hit_cell[3:0];
    h.tex      = tx[2:0];
    h.top      = y0[9:0];
    h.bottom   = y1[9:0];
    return h;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hit_t want;
    if (!rst_ni) begin
      view_x <= 13'd4224; view_y <= 13'd4224;
      dir_x <= 16'sd16384; dir_y <= 16'sd0;
      plane_x <= 16'sd0; plane_y <= 16'sd10813;
      scr_h <= 10'd240; horizon <= 10'd120;
      hits_due.delete();
      err_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_addr_i))
          REG_POS_X:         view_x  <= cfg_data_i[12:0];
          REG_POS_Y:         view_y  <= cfg_data_i[12:0];
          REG_DIR_X:         dir_x   <= cfg_data_i;
          REG_DIR_Y:         dir_y   <= cfg_data_i;
          REG_PLANE_X:       plane_x <= cfg_data_i;
          REG_PLANE_Y:       plane_y <= cfg_data_i;
          REG_SCREEN_HEIGHT: scr_h   <= cfg_data_i[9:0];
          REG_HORIZON_ROW:   horizon <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (!func_i) tile_map[cell_y_i*MapSize + cell_x_i] = {cell_solid_i, cell_tile_i};
        else hits_due.push_back(cast_ray(column_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (hits_due.size() == 0) begin
          $error("result transaction for column %0d with no cast waiting", column_out_i);
          err_count_o <= err_count_o + 1;
        end else begin
          want = hits_due.pop_front();
          if (want != {column_out_i, wall_distance_i, hit_side_i, hit_tile_i, tex_column_i,
                       span_top_i, span_bottom_i}) begin
            err_count_o <= err_count_o + 1;
            if (want.column !== column_out_i)
              $error("column_out: expected %0d, got %0d", want.column, column_out_i);
            if (want.distance !== wall_distance_i)
              $error("wall_distance: expected %0d, got %0d", want.distance, wall_distance_i);
            if (want.side !== hit_side_i)
              $error("hit_side: expected %0d, got %0d", want.side, hit_side_i);
            if (want.tile !== hit_tile_i)
              $error("hit_tile: expected %0d, got %0d", want.tile, hit_tile_i);
            if (want.tex !== tex_column_i)
              $error("tex_column: expected %0d, got %0d", want.tex, tex_column_i);
            if (want.top !== span_top_i)
              $error("span_top: expected %0d, got %0d", want.top, span_top_i);
            if (want.bottom !== span_bottom_i)
              $error("span_bottom: expected %0d, got %0d", want.bottom, span_bottom_i);
          end
        end
      end
      pending_o <= hits_due.size();
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the DDA wall column caster
// Loads the whole tile map, casts directed and random columns under several
// viewer settings with random sender gaps and receiver stalls, and leaves the
// prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb import dwc_pkg::*; ();

  // Cycles without any accepted transaction before the run is abandoned, and
  // the length of the long receiver hold-off.
  localparam int StallLimit = 20000;
  localparam int HoldCycles = 3000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                func = 1'b0;
  logic [4:0]          cell_x = '0;
  logic [4:0]          cell_y = '0;
  logic [3:0]          cell_tile = '0;
  logic                cell_solid = 1'b0;
  logic [9:0]          column = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [9:0]          column_out;
  logic [15:0]         wall_distance;
  logic                hit_side;
  logic [3:0]          hit_tile;
  logic [2:0]          tex_column;
  logic [9:0]          span_top;
  logic [9:0]          span_bottom;
  int                  err_count;
  int                  casts_pending;

  // Sender burst bookkeeping and the request counter for long hold-offs.
  int burst_left = 0;
  int hold_requests = 0;
  int idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dda_wall_column_caster_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .func_i(func), .cell_x_i(cell_x), .cell_y_i(cell_y),
    .cell_tile_i(cell_tile), .cell_solid_i(cell_solid), .column_i(column),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .column_out_o(column_out), .wall_distance_o(wall_distance),
    .hit_side_o(hit_side), .hit_tile_o(hit_tile), .tex_column_o(tex_column),
    .span_top_o(span_top), .span_bottom_o(span_bottom)
  );

  dwc_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .func_i(func), .cell_x_i(cell_x), .cell_y_i(cell_y),
    .cell_tile_i(cell_tile), .cell_solid_i(cell_solid), .column_i(column),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .column_out_i(column_out), .wall_distance_i(wall_distance),
    .hit_side_i(hit_side), .hit_tile_i(hit_tile), .tex_column_i(tex_column),
    .span_top_i(span_top), .span_bottom_i(span_bottom),
    .err_count_o(err_count), .pending_o(casts_pending)
  );

  // Receiver: for each window it picks a stall pattern (always ready, light
  // stalls, heavy stalls). A hold-off request overrides this while the hold-off
  // lasts, so the block fills up and stops taking input.
  always @(negedge clk) begin
    int mode, window, hold_left, holds_served;
    if (!rst_n) begin
      mode = 0; window = 0; hold_left = 0; holds_served = 0;
      out_ready <= 1'b0;
    end else begin
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HoldCycles;
      end
      if (window == 0) begin
        mode = $urandom_range(0, 2);
        window = 64;
      end
      window--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // Watchdog over cycles in which no transaction is accepted on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one input transaction and hold it until accepted. The sender runs
  // in bursts; between bursts valid sometimes drops for a random gap.
  task automatic push(input logic f, input logic [4:0] x, input logic [4:0] y,
                      input logic [3:0] t, input logic s, input logic [9:0] c);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk) in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    func = f; cell_x = x; cell_y = y; cell_tile = t; cell_solid = s; column = c;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic cast(input logic [9:0] c);
    push(1'b1, 5'($urandom), 5'($urandom), 4'($urandom), 1'($urandom), c);
  endtask

  task automatic write_cell(input logic [4:0] x, input logic [4:0] y);
    push(1'b0, x, y, 4'($urandom), ($urandom_range(0, 3) == 0), 10'($urandom));
  endtask

  // Pause the sender until every cast has come back, then let the block
  // finish any trailing map write before registers are touched.
  task automatic drain;
    @(negedge clk) in_valid = 1'b0;
    burst_left = 0;
    while (casts_pending != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we = 1'b1; cfg_addr = idx; cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_view(input logic [12:0] px, input logic [12:0] py,
                          input logic [15:0] dx, input logic [15:0] dy,
                          input logic [15:0] plx, input logic [15:0] ply,
                          input logic [9:0] sh, input logic [9:0] hz);
    drain();
    write_reg(REG_POS_X, 16'(px));
    write_reg(REG_POS_Y, 16'(py));
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_PLANE_X, plx);
    write_reg(REG_PLANE_Y, ply);
    write_reg(REG_SCREEN_HEIGHT, 16'(sh));
    write_reg(REG_HORIZON_ROW, 16'(hz));
  endtask

  function automatic logic [15:0] rand_dir;
    return 16'($urandom_range(0, 32768)) - 16'd16384;
  endfunction

  initial begin
    logic [9:0] sh;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Every cell is loaded before the first cast, so no ray reads an
    // unwritten cell.
    for (int y = 0; y < 32; y++)
      for (int x = 0; x < 32; x++)
        write_cell(5'(x), 5'(y));

    // Directed casts at reset settings: screen edges, center, and columns
    // beyond the screen width, which use the same formula unclamped.
    cast(10'd0); cast(10'd1); cast(10'd159); cast(10'd160);
    cast(10'd319); cast(10'd320); cast(10'd1023);

    // Extreme directions and plane, viewer at the map origin, one-row screen.
    set_view(13'd0, 13'd0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 10'd1, 10'd0);
    cast(10'd0); cast(10'd160); cast(10'd319); cast(10'd1023);

    // Both ray components zero: the walk ends at the border and the
    // distance saturates. Viewer at the far corner, horizon past the screen.
    set_view(13'd8191, 13'd8191, 16'd0, 16'd0, 16'd0, 16'd0, 10'd1023, 10'd1023);
    cast(10'd0); cast(10'd200);

    // Horizon out of range, so the span can come out inverted.
    set_view(13'd2000, 13'd6000, 16'hC000, 16'd0, 16'd0, 16'hD5C3, 10'd100, 10'd1023);
    cast(10'd5); cast(10'd300);
    write_cell(5'd0, 5'd31); write_cell(5'd31, 5'd0);

    // Random phases, each under a fresh view; one phase includes the long
    // receiver hold-off.
    for (int phase = 0; phase < 6; phase++) begin
      sh = 10'($urandom_range(1, 1023));
      set_view(13'($urandom_range(256, 7935)), 13'($urandom_range(256, 7935)),
               rand_dir(), rand_dir(), rand_dir(), rand_dir(), sh,
               10'($urandom_range(0, sh)));
      for (int i = 0; i < 43; i++) begin
        if (phase == 2 && i == 10) hold_requests++;
        if ($urandom_range(0, 9) < 6)
          cast(($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 319)));
        else
          write_cell(5'($urandom), 5'($urandom));
      end
    end

    @(negedge clk) in_valid = 1'b0;
    while (casts_pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (err_count == 0 && casts_pending == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[dda_wall_column_caster_core.f]
hw/rtl/dwc_pkg.sv
hw/rtl/dwc_divider.sv
hw/rtl/dwc_ctrl.sv
hw/rtl/dwc_datapath.sv
hw/rtl/dda_wall_column_caster_core.sv
sim/dwc_checker.sv
sim/tb.sv
